[rtl/bdar_pkg.sv]
// bdar_pkg: shared types and constants of the button debounce and auto-repeat block
// used by every rtl module of the block and by its checker
package bdar_pkg;

    localparam int unsigned NUM_BUTTONS = 3;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned IDX_W       = 2;
    localparam int unsigned REG_IDX_W   = 3;

    // item commands and pin levels
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_POLL    = 1'b1;
    localparam logic PIN_PRESSED = 1'b0;

    // button index that names no button
    localparam logic [IDX_W-1:0] IDX_NONE  = 2'd3;
    // lock register value when no button holds the machine
    localparam logic [IDX_W-1:0] LOCK_NONE = 2'd0;

    // phase codes as shown on the result port
    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_DEBOUNCE = 2'd1;
    localparam logic [1:0] PHASE_CLICKED  = 2'd2;
    localparam logic [1:0] PHASE_REPEAT   = 2'd3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_A         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_A       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_B         = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_B       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_C         = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_C       = 3'd6;

    localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS = 16'd50;
    localparam logic [CNT_W-1:0] RST_HOLD_MS        = 16'd1000;
    localparam logic [CNT_W-1:0] RST_REPEAT_MS      = 16'd200;

    typedef struct packed {
        logic [CNT_W-1:0]                  debounce_ticks;
        logic [NUM_BUTTONS-1:0][CNT_W-1:0] hold_ms;
        logic [NUM_BUTTONS-1:0][CNT_W-1:0] rpt_ms;
    } t_cfg;

    typedef struct packed {
        logic       command;
        logic [1:0] button_index;
        logic       pin_level;
    } t_item;

    typedef struct packed {
        logic       click_fire;
        logic       hold_fire;
        logic [1:0] phase;
    } t_result;

endpackage

[rtl/bdar_cfg.sv]
// bdar_cfg: configuration register file, debounce time and per-button delays
// depends on bdar_pkg
module bdar_cfg
    import bdar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_TICKS: n_cfg.debounce_ticks = i_cfg_data;
                REG_HOLD_A:         n_cfg.hold_ms[0]     = i_cfg_data;
                REG_REPEAT_A:       n_cfg.rpt_ms[0]      = i_cfg_data;
                REG_HOLD_B:         n_cfg.hold_ms[1]     = i_cfg_data;
                REG_REPEAT_B:       n_cfg.rpt_ms[1]      = i_cfg_data;
                REG_HOLD_C:         n_cfg.hold_ms[2]     = i_cfg_data;
                REG_REPEAT_C:       n_cfg.rpt_ms[2]      = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= RST_DEBOUNCE_TICKS;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_cfg.hold_ms[b] <= RST_HOLD_MS;
                r_cfg.rpt_ms[b]  <= RST_REPEAT_MS;
            end
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/bdar_core.sv]
// bdar_core: shared phase machine, countdown and button lock
// depends on bdar_pkg; takes one item per step and returns its result
module bdar_core
    import bdar_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE     = PHASE_IDLE,
        S_DEBOUNCE = PHASE_DEBOUNCE,
        S_CLICKED  = PHASE_CLICKED,
        S_REPEAT   = PHASE_REPEAT
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_lock, n_lock;

    logic [IDX_W-1:0] lock_code;
    logic             lock_ok;
    logic [CNT_W-1:0] sel_hold;
    logic [CNT_W-1:0] sel_repeat;
    logic             click;
    logic             hold;

    // per-button delay select, index 3 never reaches a load
    always_comb begin
        case (i_item.button_index)
            2'd0:    begin sel_hold = i_cfg.hold_ms[0]; sel_repeat = i_cfg.rpt_ms[0]; end
            2'd1:    begin sel_hold = i_cfg.hold_ms[1]; sel_repeat = i_cfg.rpt_ms[1]; end
            default: begin sel_hold = i_cfg.hold_ms[2]; sel_repeat = i_cfg.rpt_ms[2]; end
        endcase
    end

    assign lock_code = i_item.button_index + 2'd1;
    assign lock_ok   = (r_lock == LOCK_NONE) || (r_lock == lock_code);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_lock  = r_lock;
        click   = 1'b0;
        hold    = 1'b0;
        if (i_item.command == CMD_TICK) begin
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
        end else if (i_item.button_index != IDX_NONE && lock_ok) begin
            if (i_item.pin_level == PIN_PRESSED) begin
                if (r_phase == S_IDLE) begin
                    n_phase = S_DEBOUNCE;
                    n_count = i_cfg.debounce_ticks;
                end else if (r_count == '0) begin
                    unique case (r_phase)
                        S_DEBOUNCE: begin
                            click   = 1'b1;
                            n_phase = S_CLICKED;
                            n_count = {1'b0, sel_hold[CNT_W-1:1]};
                            n_lock  = lock_code;
                        end
                        S_CLICKED: begin
                            n_phase = S_REPEAT;
                        end
                        default: begin
                            hold    = 1'b1;
                            n_count = {1'b0, sel_repeat[CNT_W-1:1]};
                        end
                    endcase
                end
            end else if (r_phase == S_CLICKED || r_phase == S_REPEAT) begin
                // release ends the press and frees the machine
                n_phase = S_IDLE;
                n_lock  = LOCK_NONE;
            end
        end
    end

    assign o_result.click_fire = click;
    assign o_result.hold_fire  = hold;
    assign o_result.phase      = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
            r_count <= '0;
            r_lock  <= LOCK_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_lock  <= n_lock;
        end
    end

endmodule

[rtl/button_debounce_autorepeat_top.sv]
// button debounce and auto-repeat qualifier, top level
// holds the input and result registers; uses bdar_pkg, bdar_cfg and bdar_core
//
// Input channel: i_in_valid / o_in_stall carry one item, either a 2 ms tick
// or a poll of one active-low button (i_command, i_button_index, i_pin_level).
// Output channel: o_out_valid / i_out_stall carry one result per item:
// o_click_fire, o_hold_fire and o_phase (phase after the item).
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
// o_cfg_ready is always high. Write only while no item is in flight.
// Path: an accepted item is registered in the input register, handled by the phase
// machine when the output may advance, and its result is registered for the output.
// Throughput: one item per cycle while the receiver does not stall; the shared
// countdown and phase machine update their state with every item they step.
// While the receiver stalls, the result holds and one more item is taken
// into the input register; then o_in_stall rises.
// Reset clears both valid flags, the phase machine (idle, countdown zero,
// no lock) and loads the default delays.
module button_debounce_autorepeat_top
    import bdar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [1:0]           i_button_index,
    input  logic                 i_pin_level,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_click_fire,
    output logic                 o_hold_fire,
    output logic [1:0]           o_phase,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    logic adv_out;
    logic step;
    logic in_take;

    bdar_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    bdar_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign adv_out    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && adv_out;
    assign o_in_stall = r_in_valid && !adv_out;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= '{command: i_command, button_index: i_button_index,
                           pin_level: i_pin_level};
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_click_fire = r_out.click_fire;
    assign o_hold_fire  = r_out.hold_fire;
    assign o_phase      = r_out.phase;

endmodule

[rtl/bdar_checker.sv]
// bdar_props: port-level checks of the button qualifier top level
// depends on bdar_pkg; bound to button_debounce_autorepeat_top below
module bdar_props
    import bdar_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_click_fire,
    input logic       o_hold_fire,
    input logic [1:0] o_phase
);

    // the result register is empty in the cycle after reset is seen
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_fire_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_click_fire && o_hold_fire))
        else $error("click and hold fired together");

    a_click_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_click_fire) |-> (o_phase == PHASE_CLICKED))
        else $error("click without clicked phase");

    a_hold_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hold_fire) |-> (o_phase == PHASE_REPEAT))
        else $error("hold without repeat phase");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_phase)
            && $stable(o_click_fire) && $stable(o_hold_fire)))
        else $error("stalled result changed");

endmodule

bind button_debounce_autorepeat_top bdar_props u_bdar_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_click_fire (o_click_fire),
    .o_hold_fire  (o_hold_fire),
    .o_phase      (o_phase)
);
